[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define EFP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define EFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EFP_ASSERT(lbl, clk, rstn, prop, msg)
`define EFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[src/efp_pkg.sv]
// ----------------------------------------------------------------------------
// efp_pkg
// Shared widths, register codes, constants and helpers of the fisheye projector.
// ----------------------------------------------------------------------------
package efp_pkg;

    localparam int RAY_WIDTH_DEF  = 24;
    localparam int ANGLE_ITER_DEF = 20;

    localparam int CFG_W   = 24;
    localparam int IDX_W   = 2;
    localparam int OUT_W   = 28;
    localparam int MAG_W   = 32;   // |component| for rays up to 32 bits
    localparam int EXT_W   = 33;   // sign-extended component
    localparam int SQ_W    = 64;
    localparam int ROOT_STEPS = 32;
    localparam int ZK_W    = 41;
    localparam int CORD_W  = 44;
    localparam int ACC_W   = 34;
    localparam int THETA_W = 32;
    localparam int PROD_W  = 56;
    localparam int R8_W    = 27;
    localparam int NUM_W   = 60;
    localparam int QB      = 26;   // quotient bits, offset magnitude < 2^26
    localparam int REM_W   = 32;
    localparam int K_W     = 6;
    localparam int BL_W    = 7;
    localparam int SUM_W   = 29;

    typedef enum logic [IDX_W-1:0] {
        REG_CENTRE_X     = 2'd0,
        REG_CENTRE_Y     = 2'd1,
        REG_RADIAL_SCALE = 2'd2
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] CENTRE_X_RST     = 24'd81920;
    localparam logic [CFG_W-1:0] CENTRE_Y_RST     = 24'd61440;
    localparam logic [CFG_W-1:0] RADIAL_SCALE_RST = 24'd65536;

    localparam logic signed [ACC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic [THETA_W-1:0]      PI_Q30      = 32'd3373259426;

    typedef struct packed {
        logic             on_axis;
        logic             sx;
        logic             sy;
        logic [MAG_W-1:0] mx;
        logic [MAG_W-1:0] my;
    } side_t;

    // atan(2^-i) in Q2.30
    function automatic logic [THETA_W-1:0] atan_entry(input int i);
        logic [THETA_W-1:0] r;
        begin
            case (i)
                0:  r = 32'd843314857;
                1:  r = 32'd497837829;
                2:  r = 32'd263043837;
                3:  r = 32'd133525159;
                4:  r = 32'd67021687;
                5:  r = 32'd33543516;
                6:  r = 32'd16775851;
                7:  r = 32'd8388437;
                8:  r = 32'd4194283;
                9:  r = 32'd2097149;
                10: r = 32'd1048576;
                default: r = (i <= 30) ? (32'd1 << (30 - i)) : 32'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [BL_W-1:0] bit_len64(input logic [SQ_W-1:0] v);
        logic [BL_W-1:0] n;
        begin
            n = '0;
            for (int i = 0; i < SQ_W; i++)
            begin
                if (v[i])
                    n = BL_W'(i + 1);
            end
            return n;
        end
    endfunction

endpackage

[src/efp_if.sv]
// ----------------------------------------------------------------------------
// efp_ray_if / efp_pixel_if
// Valid/ready channels carrying one ray word and one pixel word.
// ----------------------------------------------------------------------------
interface efp_ray_if #(parameter int RAY_WIDTH = 24);
    logic                 valid;
    logic                 ready;
    logic [RAY_WIDTH-1:0] ray_x;
    logic [RAY_WIDTH-1:0] ray_y;
    logic [RAY_WIDTH-1:0] ray_z;
    modport source (output valid, ray_x, ray_y, ray_z, input ready);
    modport sink   (input valid, ray_x, ray_y, ray_z, output ready);
endinterface

interface efp_pixel_if import efp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] pixel_u;
    logic [OUT_W-1:0] pixel_v;
    logic             on_axis;
    modport source (output valid, pixel_u, pixel_v, on_axis, input ready);
    modport sink   (input valid, pixel_u, pixel_v, on_axis, output ready);
endinterface

[src/efp_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// efp_sqrt_cell
// One digit of the integer square root; passes ray data along.
// ----------------------------------------------------------------------------
module efp_sqrt_cell import efp_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   vin,
    input  logic [SQ_W-1:0]        rem_in,
    input  logic [SQ_W-1:0]        root_in,
    input  logic signed [ZK_W-1:0] zk_in,
    input  side_t                  side_in,
    output logic                   vout,
    output logic [SQ_W-1:0]        rem_out,
    output logic [SQ_W-1:0]        root_out,
    output logic signed [ZK_W-1:0] zk_out,
    output side_t                  side_out
);

    localparam logic [SQ_W-1:0] BIT = 64'd1 << (62 - 2 * STEP);

    logic            vld_reg;
    logic [SQ_W-1:0] rem_reg, rem_next, root_reg, root_next, trial;
    logic signed [ZK_W-1:0] zk_reg;
    side_t           side_reg;

    always_comb
    begin
        trial = root_in + BIT;
        if (rem_in >= trial)
        begin
            rem_next  = rem_in - trial;
            root_next = (root_in >> 1) + BIT;
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            zk_reg   <= zk_in;
            side_reg <= side_in;
        end
    end

    assign vout     = vld_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign zk_out   = zk_reg;
    assign side_out = side_reg;

endmodule

[src/efp_cordic_cell.sv]
// ----------------------------------------------------------------------------
// efp_cordic_cell
// One CORDIC vectoring micro-rotation accumulating the off-axis angle.
// ----------------------------------------------------------------------------
module efp_cordic_cell import efp_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     vin,
    input  logic signed [CORD_W-1:0] x_in,
    input  logic signed [CORD_W-1:0] y_in,
    input  logic signed [ACC_W-1:0]  acc_in,
    input  logic [MAG_W-1:0]         rho_in,
    input  side_t                    side_in,
    output logic                     vout,
    output logic signed [CORD_W-1:0] x_out,
    output logic signed [CORD_W-1:0] y_out,
    output logic signed [ACC_W-1:0]  acc_out,
    output logic [MAG_W-1:0]         rho_out,
    output side_t                    side_out
);

    localparam logic signed [ACC_W-1:0] ANG = $signed({2'b00, atan_entry(IDX)});

    logic                     vld_reg;
    logic signed [CORD_W-1:0] x_reg, x_next, y_reg, y_next, dx, dy;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [MAG_W-1:0]         rho_reg;
    side_t                    side_reg;

    always_comb
    begin
        dx = y_in >>> IDX;
        dy = x_in >>> IDX;
        if (!y_in[CORD_W-1])
        begin
            x_next   = x_in + dx;
            y_next   = y_in - dy;
            acc_next = acc_in + ANG;
        end
        else
        begin
            x_next   = x_in - dx;
            y_next   = y_in + dy;
            acc_next = acc_in - ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            acc_reg  <= acc_next;
            rho_reg  <= rho_in;
            side_reg <= side_in;
        end
    end

    assign vout     = vld_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign acc_out  = acc_reg;
    assign rho_out  = rho_reg;
    assign side_out = side_reg;

endmodule

[src/efp_div_cell.sv]
// ----------------------------------------------------------------------------
// efp_div_cell
// One restoring quotient bit for both the u and v lanes.
// ----------------------------------------------------------------------------
module efp_div_cell import efp_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              vin,
    input  logic [MAG_W-1:0]  den_in,
    input  logic [NUM_W-1:0]  nu_in,
    input  logic [NUM_W-1:0]  nv_in,
    input  logic [REM_W-1:0]  ru_in,
    input  logic [REM_W-1:0]  rv_in,
    input  logic [QB-1:0]     qu_in,
    input  logic [QB-1:0]     qv_in,
    input  side_t             side_in,
    output logic              vout,
    output logic [MAG_W-1:0]  den_out,
    output logic [NUM_W-1:0]  nu_out,
    output logic [NUM_W-1:0]  nv_out,
    output logic [REM_W-1:0]  ru_out,
    output logic [REM_W-1:0]  rv_out,
    output logic [QB-1:0]     qu_out,
    output logic [QB-1:0]     qv_out,
    output side_t             side_out
);

    localparam int POS = QB - 1 - IDX;

    logic             vld_reg;
    logic [MAG_W-1:0] den_reg;
    logic [NUM_W-1:0] nu_reg, nv_reg;
    logic [REM_W-1:0] ru_reg, ru_next, rv_reg, rv_next;
    logic [QB-1:0]    qu_reg, qu_next, qv_reg, qv_next;
    logic [REM_W:0]   tu, tv, dext;
    side_t            side_reg;

    always_comb
    begin
        dext = {1'b0, den_in};
        tu   = {ru_in, nu_in[POS]};
        tv   = {rv_in, nv_in[POS]};
        if (tu >= dext)
        begin
            ru_next = REM_W'(tu - dext);
            qu_next = {qu_in[QB-2:0], 1'b1};
        end
        else
        begin
            ru_next = REM_W'(tu);
            qu_next = {qu_in[QB-2:0], 1'b0};
        end
        if (tv >= dext)
        begin
            rv_next = REM_W'(tv - dext);
            qv_next = {qv_in[QB-2:0], 1'b1};
        end
        else
        begin
            rv_next = REM_W'(tv);
            qv_next = {qv_in[QB-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg  <= den_in;
            nu_reg   <= nu_in;
            nv_reg   <= nv_in;
            ru_reg   <= ru_next;
            rv_reg   <= rv_next;
            qu_reg   <= qu_next;
            qv_reg   <= qv_next;
            side_reg <= side_in;
        end
    end

    assign vout     = vld_reg;
    assign den_out  = den_reg;
    assign nu_out   = nu_reg;
    assign nv_out   = nv_reg;
    assign ru_out   = ru_reg;
    assign rv_out   = rv_reg;
    assign qu_out   = qu_reg;
    assign qv_out   = qv_reg;
    assign side_out = side_reg;

endmodule

[src/equidistant_fisheye_project.sv]
// ----------------------------------------------------------------------------
// equidistant_fisheye_project
// Equidistant fisheye projection of a 3D ray to a Q.8 pixel position.
// ----------------------------------------------------------------------------
// Usage:
//   ray   : valid/ready sink, one word = (ray_x, ray_y, ray_z), signed.
//   pixel : valid/ready source, one word = (pixel_u, pixel_v, on_axis).
//   cfg   : write port (cfg_we, cfg_index, cfg_data) for centre_x, centre_y
//           and radial_scale; write only while no ray is in flight.
// Throughput: one ray word per cycle, every cycle the output is free.
// Chain: 5 prep stages, 32 square-root digit cells, CORDIC init, one CORDIC
//   cell per angle iteration, 5 scale/multiply stages, 26 divider cells,
//   and the output register.
// The whole chain moves on one advance strobe: when the pixel word is held
// by the receiver, the chain freezes and ray.ready drops; nothing is lost.
// Reset clears all valid flags and loads the default camera registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module equidistant_fisheye_project import efp_pkg::*; #(
    parameter int RAY_WIDTH        = RAY_WIDTH_DEF,
    parameter int ANGLE_ITERATIONS = ANGLE_ITER_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    efp_ray_if.sink          ray,
    efp_pixel_if.source      pixel,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int NI = ANGLE_ITERATIONS;

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] centre_x_reg, centre_y_reg, radial_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_x_reg     <= CENTRE_X_RST;
            centre_y_reg     <= CENTRE_Y_RST;
            radial_scale_reg <= RADIAL_SCALE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CENTRE_X:     centre_x_reg     <= cfg_data;
                REG_CENTRE_Y:     centre_y_reg     <= cfg_data;
                REG_RADIAL_SCALE: radial_scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // whole chain advances together; the output register is the last stage
    logic out_vld_reg;
    logic adv;
    assign adv       = !out_vld_reg || pixel.ready;
    assign ray.ready = adv;

    // ---------------- s0: sign extend, magnitudes ----------------
    logic signed [EXT_W-1:0] x_ext, y_ext, z_ext, x_abs, y_abs, z_abs;
    logic        s0_vld_reg;
    logic signed [EXT_W-1:0] s0_z_reg;
    logic [MAG_W-1:0] s0_az_reg;
    side_t       s0_side_reg;

    always_comb
    begin
        x_ext = $signed({{(EXT_W-RAY_WIDTH){ray.ray_x[RAY_WIDTH-1]}}, ray.ray_x});
        y_ext = $signed({{(EXT_W-RAY_WIDTH){ray.ray_y[RAY_WIDTH-1]}}, ray.ray_y});
        z_ext = $signed({{(EXT_W-RAY_WIDTH){ray.ray_z[RAY_WIDTH-1]}}, ray.ray_z});
        x_abs = x_ext[EXT_W-1] ? -x_ext : x_ext;
        y_abs = y_ext[EXT_W-1] ? -y_ext : y_ext;
        z_abs = z_ext[EXT_W-1] ? -z_ext : z_ext;
    end

    // ---------------- s1: squares; s2: sum; s3: shift amount ----------------
    logic        s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [SQ_W-1:0] s1_sqx_reg, s1_sqy_reg, s2_s_reg, s3_s_reg;
    logic signed [EXT_W-1:0] s1_z_reg, s2_z_reg, s3_z_reg;
    logic [MAG_W-1:0] s1_az_reg, s2_az_reg;
    side_t       s1_side_reg, s2_side_reg, s3_side_reg;
    logic [K_W-1:0] s3_k_reg, k_next;
    logic [BL_W-1:0] bl_s, bl_z, ks, kz;

    always_comb
    begin
        bl_s   = bit_len64(s2_s_reg);
        bl_z   = bit_len64({32'd0, s2_az_reg});
        ks     = (BL_W'(64) - bl_s) >> 1;
        kz     = BL_W'(40) - bl_z;
        k_next = (kz < ks) ? K_W'(kz) : K_W'(ks);
    end

    // ---------------- s4: scaled operands (sqrt chain entry) ----------------
    logic [SQ_W-1:0] sq_rem [0:ROOT_STEPS];
    logic [SQ_W-1:0] sq_root[0:ROOT_STEPS];
    logic signed [ZK_W-1:0] sq_zk[0:ROOT_STEPS];
    side_t       sq_side[0:ROOT_STEPS];
    logic        sq_vld [0:ROOT_STEPS];

    logic        s4_vld_reg;
    logic [SQ_W-1:0] s4_rem_reg;
    logic signed [ZK_W-1:0] s4_zk_reg, zk_next;
    side_t       s4_side_reg, s4_side_next;

    always_comb
    begin
        zk_next = $signed({{(ZK_W-EXT_W){s3_z_reg[EXT_W-1]}}, s3_z_reg}) <<< s3_k_reg;
        s4_side_next    = s3_side_reg;
        s4_side_next.mx = MAG_W'({32'd0, s3_side_reg.mx} << s3_k_reg);
        s4_side_next.my = MAG_W'({32'd0, s3_side_reg.my} << s3_k_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg <= ray.valid;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_z_reg            <= z_ext;
            s0_az_reg           <= MAG_W'(z_abs);
            s0_side_reg.on_axis <= (x_ext == '0) && (y_ext == '0);
            s0_side_reg.sx      <= x_ext[EXT_W-1];
            s0_side_reg.sy      <= y_ext[EXT_W-1];
            s0_side_reg.mx      <= MAG_W'(x_abs);
            s0_side_reg.my      <= MAG_W'(y_abs);

            s1_sqx_reg  <= s0_side_reg.mx * s0_side_reg.mx;
            s1_sqy_reg  <= s0_side_reg.my * s0_side_reg.my;
            s1_z_reg    <= s0_z_reg;
            s1_az_reg   <= s0_az_reg;
            s1_side_reg <= s0_side_reg;

            s2_s_reg    <= s1_sqx_reg + s1_sqy_reg;
            s2_z_reg    <= s1_z_reg;
            s2_az_reg   <= s1_az_reg;
            s2_side_reg <= s1_side_reg;

            s3_s_reg    <= s2_s_reg;
            s3_k_reg    <= k_next;
            s3_z_reg    <= s2_z_reg;
            s3_side_reg <= s2_side_reg;

            s4_rem_reg  <= s3_s_reg << {s3_k_reg, 1'b0};
            s4_zk_reg   <= zk_next;
            s4_side_reg <= s4_side_next;
        end
    end

    assign sq_vld[0]  = s4_vld_reg;
    assign sq_rem[0]  = s4_rem_reg;
    assign sq_root[0] = '0;
    assign sq_zk[0]   = s4_zk_reg;
    assign sq_side[0] = s4_side_reg;

    // ---------------- square-root digit chain ----------------
    for (genvar j = 0; j < ROOT_STEPS; j++)
    begin : g_sqrt
        efp_sqrt_cell #(.STEP(j)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .vin     (sq_vld[j]),
            .rem_in  (sq_rem[j]),
            .root_in (sq_root[j]),
            .zk_in   (sq_zk[j]),
            .side_in (sq_side[j]),
            .vout    (sq_vld[j+1]),
            .rem_out (sq_rem[j+1]),
            .root_out(sq_root[j+1]),
            .zk_out  (sq_zk[j+1]),
            .side_out(sq_side[j+1])
        );
    end

    // ---------------- CORDIC init: fold rays behind the camera ----------------
    logic signed [CORD_W-1:0] c_x  [0:NI];
    logic signed [CORD_W-1:0] c_y  [0:NI];
    logic signed [ACC_W-1:0]  c_acc[0:NI];
    logic [MAG_W-1:0]         c_rho[0:NI];
    side_t                    c_side[0:NI];
    logic                     c_vld[0:NI];

    logic [MAG_W-1:0] rho;
    logic signed [CORD_W-1:0] zk_w, rho_w;
    logic        ci_vld_reg;
    logic signed [CORD_W-1:0] ci_x_reg, ci_y_reg;
    logic signed [ACC_W-1:0]  ci_acc_reg;
    logic [MAG_W-1:0] ci_rho_reg;
    side_t       ci_side_reg;

    always_comb
    begin
        rho   = MAG_W'(sq_root[ROOT_STEPS]);
        zk_w  = CORD_W'(sq_zk[ROOT_STEPS]);
        rho_w = $signed({{(CORD_W-MAG_W){1'b0}}, rho});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ci_vld_reg <= 1'b0;
        else if (adv)
            ci_vld_reg <= sq_vld[ROOT_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (zk_w[CORD_W-1])
            begin
                // rotate by -pi/2, angle starts at pi/2
                ci_x_reg   <= rho_w;
                ci_y_reg   <= -zk_w;
                ci_acc_reg <= HALF_PI_Q30;
            end
            else
            begin
                ci_x_reg   <= zk_w;
                ci_y_reg   <= rho_w;
                ci_acc_reg <= '0;
            end
            ci_rho_reg  <= rho;
            ci_side_reg <= sq_side[ROOT_STEPS];
        end
    end

    assign c_vld[0]  = ci_vld_reg;
    assign c_x[0]    = ci_x_reg;
    assign c_y[0]    = ci_y_reg;
    assign c_acc[0]  = ci_acc_reg;
    assign c_rho[0]  = ci_rho_reg;
    assign c_side[0] = ci_side_reg;

    for (genvar i = 0; i < NI; i++)
    begin : g_cordic
        efp_cordic_cell #(.IDX(i)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .vin     (c_vld[i]),
            .x_in    (c_x[i]),
            .y_in    (c_y[i]),
            .acc_in  (c_acc[i]),
            .rho_in  (c_rho[i]),
            .side_in (c_side[i]),
            .vout    (c_vld[i+1]),
            .x_out   (c_x[i+1]),
            .y_out   (c_y[i+1]),
            .acc_out (c_acc[i+1]),
            .rho_out (c_rho[i+1]),
            .side_out(c_side[i+1])
        );
    end

    // ---------------- clamp, radius, numerators, dividend ----------------
    logic signed [ACC_W-1:0] acc_f;
    logic [THETA_W-1:0] theta_next;
    logic        t_vld_reg, p_vld_reg, r_vld_reg, m_vld_reg, n_vld_reg;
    logic [THETA_W-1:0] t_theta_reg;
    logic [PROD_W-1:0]  p_prod_reg;
    logic [R8_W-1:0]    r_r8_reg;
    logic [NUM_W-1:0]   m_nu_reg, m_nv_reg, n_nu_reg, n_nv_reg;
    logic [MAG_W-1:0]   t_rho_reg, p_rho_reg, r_rho_reg, m_rho_reg, n_rho_reg;
    side_t       t_side_reg, p_side_reg, r_side_reg, m_side_reg, n_side_reg;

    always_comb
    begin
        acc_f = c_acc[NI];
        if (acc_f[ACC_W-1])
            theta_next = '0;
        else if (acc_f > $signed({2'b00, PI_Q30}))
            theta_next = PI_Q30;
        else
            theta_next = THETA_W'(acc_f);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
            r_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            n_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            t_vld_reg <= c_vld[NI];
            p_vld_reg <= t_vld_reg;
            r_vld_reg <= p_vld_reg;
            m_vld_reg <= r_vld_reg;
            n_vld_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_theta_reg <= theta_next;
            t_rho_reg   <= c_rho[NI];
            t_side_reg  <= c_side[NI];

            p_prod_reg  <= radial_scale_reg * t_theta_reg;
            p_rho_reg   <= t_rho_reg;
            p_side_reg  <= t_side_reg;

            // round half up from Q30 down to Q.8
            r_r8_reg    <= R8_W'(({1'b0, p_prod_reg} + 57'd536870912) >> 30);
            r_rho_reg   <= p_rho_reg;
            r_side_reg  <= p_side_reg;

            m_nu_reg    <= NUM_W'(r_r8_reg * r_side_reg.mx);
            m_nv_reg    <= NUM_W'(r_r8_reg * r_side_reg.my);
            m_rho_reg   <= r_rho_reg;
            m_side_reg  <= r_side_reg;

            n_nu_reg    <= m_nu_reg + NUM_W'(m_rho_reg >> 1);
            n_nv_reg    <= m_nv_reg + NUM_W'(m_rho_reg >> 1);
            n_rho_reg   <= m_rho_reg;
            n_side_reg  <= m_side_reg;
        end
    end

    // ---------------- divider chain ----------------
    logic [MAG_W-1:0] d_den [0:QB];
    logic [NUM_W-1:0] d_nu  [0:QB];
    logic [NUM_W-1:0] d_nv  [0:QB];
    logic [REM_W-1:0] d_ru  [0:QB];
    logic [REM_W-1:0] d_rv  [0:QB];
    logic [QB-1:0]    d_qu  [0:QB];
    logic [QB-1:0]    d_qv  [0:QB];
    side_t            d_side[0:QB];
    logic             d_vld [0:QB];

    // quotient fits QB bits, so the top part of the dividend is below den
    assign d_vld[0]  = n_vld_reg;
    assign d_den[0]  = n_rho_reg;
    assign d_nu[0]   = n_nu_reg;
    assign d_nv[0]   = n_nv_reg;
    assign d_ru[0]   = REM_W'(n_nu_reg >> QB);
    assign d_rv[0]   = REM_W'(n_nv_reg >> QB);
    assign d_qu[0]   = '0;
    assign d_qv[0]   = '0;
    assign d_side[0] = n_side_reg;

    for (genvar q = 0; q < QB; q++)
    begin : g_div
        efp_div_cell #(.IDX(q)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .vin     (d_vld[q]),
            .den_in  (d_den[q]),
            .nu_in   (d_nu[q]),
            .nv_in   (d_nv[q]),
            .ru_in   (d_ru[q]),
            .rv_in   (d_rv[q]),
            .qu_in   (d_qu[q]),
            .qv_in   (d_qv[q]),
            .side_in (d_side[q]),
            .vout    (d_vld[q+1]),
            .den_out (d_den[q+1]),
            .nu_out  (d_nu[q+1]),
            .nv_out  (d_nv[q+1]),
            .ru_out  (d_ru[q+1]),
            .rv_out  (d_rv[q+1]),
            .qu_out  (d_qu[q+1]),
            .qv_out  (d_qv[q+1]),
            .side_out(d_side[q+1])
        );
    end

    // ---------------- output: sign, centre, saturate ----------------
    function automatic logic [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
        logic [OUT_W-1:0] r;
        begin
            if (v > $signed(SUM_W'(134217727)))
                r = {1'b0, {(OUT_W-1){1'b1}}};
            else if (v < -$signed(SUM_W'(134217728)))
                r = {1'b1, {(OUT_W-1){1'b0}}};
            else
                r = OUT_W'(v);
            return r;
        end
    endfunction

    side_t fin_side;
    logic signed [SUM_W-1:0] cxs, cys, off_u, off_v;
    logic [OUT_W-1:0] u_next, v_next;
    logic [OUT_W-1:0] out_u_reg, out_v_reg;
    logic             out_axis_reg;

    always_comb
    begin
        fin_side = d_side[QB];
        cxs   = $signed({{(SUM_W-CFG_W){1'b0}}, centre_x_reg});
        cys   = $signed({{(SUM_W-CFG_W){1'b0}}, centre_y_reg});
        off_u = $signed({{(SUM_W-QB){1'b0}}, d_qu[QB]});
        off_v = $signed({{(SUM_W-QB){1'b0}}, d_qv[QB]});
        if (fin_side.sx)
            off_u = -off_u;
        if (fin_side.sy)
            off_v = -off_v;
        if (fin_side.on_axis)
        begin
            u_next = OUT_W'(centre_x_reg);
            v_next = OUT_W'(centre_y_reg);
        end
        else
        begin
            u_next = sat_out(cxs + off_u);
            v_next = sat_out(cys + off_v);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= d_vld[QB];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_u_reg    <= u_next;
            out_v_reg    <= v_next;
            out_axis_reg <= fin_side.on_axis;
        end
    end

    assign pixel.valid   = out_vld_reg;
    assign pixel.pixel_u = out_u_reg;
    assign pixel.pixel_v = out_v_reg;
    assign pixel.on_axis = out_axis_reg;

    // ---------------- checks ----------------
    logic signed [SUM_W-1:0] du_chk;
    assign du_chk = $signed({pixel.pixel_u[OUT_W-1], pixel.pixel_u}) - cxs;

    `EFP_ASSERT(a_axis_u, clk, rst_n, pixel.valid && pixel.on_axis |-> pixel.pixel_u == OUT_W'(centre_x_reg), "on-axis u is not centre_x")
    `EFP_ASSERT(a_axis_v, clk, rst_n, pixel.valid && pixel.on_axis |-> pixel.pixel_v == OUT_W'(centre_y_reg), "on-axis v is not centre_y")
    `EFP_ASSERT(a_off_range, clk, rst_n, pixel.valid |-> (du_chk <= $signed(SUM_W'(67108864))) && (du_chk >= -$signed(SUM_W'(67108864))), "u offset beyond radius range")
    `EFP_ASSERT_NEXT(a_cfg_cx, clk, rst_n, cfg_we && (cfg_index == REG_CENTRE_X), centre_x_reg == $past(cfg_data), "centre_x write lost")

endmodule
